// ===== rtl/core/nwt_pkg.sv =====
package nwt_pkg;

  localparam int unsigned VALUE_BITS_DEF = 40;
  localparam int unsigned CONV_BITS      = 40;
  localparam int unsigned NUM_DIGITS     = 12;
  localparam int unsigned DIGIT_BITS     = 4;
  localparam int unsigned CONV_PER_STEP  = 4;
  localparam int unsigned CONV_STEPS     = CONV_BITS / CONV_PER_STEP;
  localparam int unsigned WORD_BITS      = 6;

  localparam logic [CONV_BITS-1:0] LIMIT = 40'd1_000_000_000_000;

  localparam logic [WORD_BITS-1:0] TOK_EMPTY     = 6'd0;
  localparam logic [WORD_BITS-1:0] TOK_TEEN_BASE = 6'd10;
  localparam logic [WORD_BITS-1:0] TOK_TENS_BASE = 6'd18;
  localparam logic [WORD_BITS-1:0] TOK_HUNDRED   = 6'd28;
  localparam logic [WORD_BITS-1:0] TOK_THOUSAND  = 6'd29;
  localparam logic [WORD_BITS-1:0] TOK_MILLION   = 6'd30;
  localparam logic [WORD_BITS-1:0] TOK_BILLION   = 6'd31;
  localparam logic [WORD_BITS-1:0] TOK_ERROR     = 6'd32;

  typedef logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0] digits_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT,
    S_ONE
  } state_e;

  typedef enum logic [2:0] {
    P_HDIG,
    P_HUND,
    P_TENS,
    P_ONES,
    P_SCALE
  } phase_e;

endpackage

// ===== rtl/core/nwt_if.sv =====
interface nwt_in_if #(
  parameter int unsigned VALUE_BITS = nwt_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface nwt_out_if;
  logic                           valid;
  logic                           ready;
  logic [nwt_pkg::WORD_BITS-1:0] word;
  logic                           last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

// ===== rtl/core/nwt_b2d.sv =====
module nwt_b2d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nwt_pkg::CONV_BITS-1:0] bin_i,
  output logic                          done_o,
  output nwt_pkg::digits_t              digits_o
);
  import nwt_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CONV_STEPS);
  localparam int unsigned BCD_W  = NUM_DIGITS * DIGIT_BITS;

  logic [CONV_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic b);
    logic [BCD_W-1:0]      adj;
    logic [DIGIT_BITS-1:0] dig;
    adj = bcd;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      dig = bcd[k*DIGIT_BITS +: DIGIT_BITS];
      if (dig >= 4'd5) begin
        adj[k*DIGIT_BITS +: DIGIT_BITS] = dig + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      for (int s = 0; s < CONV_PER_STEP; s++) begin
        bcd_d = dabble(bcd_d, bin_d[CONV_BITS-1]);
        bin_d = {bin_d[CONV_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(CONV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = digits_t'(bcd_q);

endmodule

// ===== rtl/core/number_to_word_tokens.sv =====
// Spells an unsigned number as English word tokens, one token per output transfer, with
// last set on the final token. A nonzero number below 10^12 is first turned into twelve
// decimal digits by a double-dabble unit that takes four bits per cycle, then a
// sequencer walks the billion, million, thousand and unit groups through five token
// slots each (hundreds digit, hundred, tens or teen, ones, scale word) at one slot per
// cycle unless a stalled output holds back a slot with a token, also stepping through
// slots with no token, and stops once the final token is in the output register. Zero
// gives one empty token and 10^12 or more one error token. The input is not ready while
// a number is in progress; the next number is taken once its final token sits in the
// output register.
module number_to_word_tokens #(
  parameter int unsigned VALUE_BITS = nwt_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nwt_in_if.sink    in_i,
  nwt_out_if.source out_o
);
  import nwt_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [1:0] group_q, group_d;
  logic one_err_q, one_err_d;

  logic                 out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0] out_word_q, out_word_d;
  logic                 out_last_q, out_last_d;

  logic [VALUE_BITS-1:0] in_value;
  logic                  in_fire, in_err, in_zero, high_set;
  logic                  conv_start, conv_done;
  digits_t               digits;

  logic [DIGIT_BITS-1:0] dh, dt;
  logic [DIGIT_BITS-1:0] d_ones;
  logic [3:0]            gnz;
  logic [4:0]            ex;
  logic                  more_grp, more_in, tok_ex, tok_last, slot_free;
  logic [WORD_BITS-1:0]  tok_word;

  assign in_value = in_i.value;
  assign in_fire  = in_i.valid && in_i.ready;

  if (VALUE_BITS > CONV_BITS) begin : g_high
    assign high_set = |in_value[VALUE_BITS-1:CONV_BITS];
  end else begin : g_nohigh
    assign high_set = 1'b0;
  end

  assign in_err     = high_set || (in_value[CONV_BITS-1:0] >= LIMIT);
  assign in_zero    = (in_value[CONV_BITS-1:0] == '0) && !high_set;
  assign conv_start = in_fire && !in_err && !in_zero;

  nwt_b2d u_b2d (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .bin_i    (in_value[CONV_BITS-1:0]),
    .done_o   (conv_done),
    .digits_o (digits)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      gnz[i] = (digits[(3-i)*3+2] != '0) || (digits[(3-i)*3+1] != '0) ||
               (digits[(3-i)*3] != '0);
    end
  end

  always_comb begin
    dh = digits[11]; dt = digits[10]; d_ones = digits[9]; more_grp = |gnz[3:1];
    case (group_q)
      2'd0: begin
        dh = digits[11]; dt = digits[10]; d_ones = digits[9]; more_grp = |gnz[3:1];
      end
      2'd1: begin
        dh = digits[8]; dt = digits[7]; d_ones = digits[6]; more_grp = |gnz[3:2];
      end
      2'd2: begin
        dh = digits[5]; dt = digits[4]; d_ones = digits[3]; more_grp = gnz[3];
      end
      default: begin
        dh = digits[2]; dt = digits[1]; d_ones = digits[0]; more_grp = 1'b0;
      end
    endcase
  end

  always_comb begin
    ex[0] = dh != '0;
    ex[1] = dh != '0;
    ex[2] = dt != '0;
    ex[3] = (dt != 4'd1) && (d_ones != '0);
    ex[4] = gnz[group_q] && (group_q != 2'd3);
  end

  always_comb begin
    tok_ex   = 1'b0;
    more_in  = 1'b0;
    tok_word = TOK_EMPTY;
    case (phase_q)
      P_HDIG: begin
        tok_ex = ex[0]; more_in = |ex[4:1]; tok_word = WORD_BITS'(dh);
      end
      P_HUND: begin
        tok_ex = ex[1]; more_in = |ex[4:2]; tok_word = TOK_HUNDRED;
      end
      P_TENS: begin
        tok_ex  = ex[2];
        more_in = |ex[4:3];
        tok_word = (dt == 4'd1) ? TOK_TEEN_BASE + WORD_BITS'(d_ones)
                                : TOK_TENS_BASE + WORD_BITS'(dt);
      end
      P_ONES: begin
        tok_ex = ex[3]; more_in = ex[4]; tok_word = WORD_BITS'(d_ones);
      end
      P_SCALE: begin
        tok_ex = ex[4]; more_in = 1'b0; tok_word = TOK_BILLION - WORD_BITS'(group_q);
      end
      default: begin
        tok_ex = 1'b0; more_in = 1'b0; tok_word = TOK_EMPTY;
      end
    endcase
  end

  assign tok_last  = !(more_in || more_grp);
  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_err || in_zero) ? S_ONE : S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (tok_ex && slot_free && tok_last) begin
          state_d = S_IDLE;
        end
      end
      S_ONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    group_d     = group_q;
    phase_d     = phase_q;
    one_err_d   = one_err_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        one_err_d = in_err;
        group_d   = 2'd0;
        phase_d   = P_HDIG;
      end
      S_CONV: begin
        group_d = 2'd0;
        phase_d = P_HDIG;
      end
      S_EMIT: begin
        if (tok_ex && slot_free) begin
          out_valid_d = 1'b1;
          out_word_d  = tok_word;
          out_last_d  = tok_last;
        end
        if (!tok_ex || slot_free) begin
          if (phase_q == P_SCALE) begin
            phase_d = P_HDIG;
            group_d = group_q + 2'd1;
          end else begin
            phase_d = phase_e'(phase_q + 3'd1);
          end
        end
      end
      S_ONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_word_d  = one_err_q ? TOK_ERROR : TOK_EMPTY;
          out_last_d  = 1'b1;
        end
      end
      default: begin
        group_d = 2'd0;
        phase_d = P_HDIG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= P_HDIG;
      group_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      group_q     <= group_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    one_err_q  <= one_err_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;
  assign out_o.last  = out_last_q;

endmodule

// ===== rtl/core/nwt_checker.sv =====
module nwt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [nwt_pkg::WORD_BITS-1:0] out_word_i,
  input logic                          out_last_i
);
  import nwt_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a token run");

  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_word_i <= TOK_ERROR)
    else $error("token code out of range");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_word_i == TOK_EMPTY || out_word_i == TOK_ERROR) |-> out_last_i)
    else $error("empty or error token without last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i) && $stable(out_last_i))
    else $error("stalled output changed");

endmodule

bind number_to_word_tokens nwt_checker u_nwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.word),
  .out_last_i  (out_o.last)
);
